/* rtl/acss_pkg.sv */
// Shared types, constants and helpers for the ADC channel scan sequencer.
// No dependencies; every other file uses this package by scoped names.
`default_nettype none

package acss_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int SAMPLE_BITS  = 10;
  localparam int IDX_BITS     = 3;
  localparam int COUNT_BITS   = 4;
  localparam int MUX_BITS     = 5;
  localparam int LIST_BITS    = MAX_CHANNELS * MUX_BITS;
  localparam int CMD_BITS     = 2;
  localparam int STATUS_BITS  = 2;
  localparam int CFG_ADDR_BITS = 1;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_BITS    = 1;

  localparam logic [CFG_ADDR_BITS-1:0] CFG_ACTIVE_COUNT = 1'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_CHANNEL_LIST = 1'd1;

  localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_BUSY      = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd2;

  localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(MAX_CHANNELS);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_START    = 2'd0,
    CMD_CONV     = 2'd1,
    CMD_READ_CH  = 2'd2,
    CMD_READ_ALL = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                   op;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   hit;
    logic [IDX_BITS-1:0]    idx;
  } op_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [COUNT_BITS-1:0] eff_count(input logic [COUNT_BITS-1:0] c);
    logic [COUNT_BITS-1:0] r;
    r = c;
    if (c == '0) begin
      r = COUNT_BITS'(1);
    end else if (c > COUNT_BITS'(MAX_CHANNELS)) begin
      r = COUNT_BITS'(MAX_CHANNELS);
    end
    return r;
  endfunction

  function automatic logic [MUX_BITS-1:0] list_entry(input logic [LIST_BITS-1:0] list,
                                                     input logic [IDX_BITS-1:0] i);
    return list[i*MUX_BITS +: MUX_BITS];
  endfunction

endpackage

`default_nettype wire

/* rtl/acss_front.sv */
// Front end: decodes each transaction and searches the scan list for read-channel.
// Depends on acss_pkg.
`default_nettype none

module acss_front (
  input  wire logic [acss_pkg::CMD_BITS-1:0]    in_cmd,
  input  wire logic [acss_pkg::SAMPLE_BITS-1:0] in_sample,
  input  wire logic [acss_pkg::MUX_BITS-1:0]    in_channel,
  input  wire logic [acss_pkg::COUNT_BITS-1:0]  count,
  input  wire logic [acss_pkg::LIST_BITS-1:0]   channel_list,
  output acss_pkg::op_entry_t                   entry
);

  logic                             hit;
  logic [acss_pkg::IDX_BITS-1:0]    hit_idx;

  // lowest matching position wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = acss_pkg::MAX_CHANNELS - 1; i >= 0; i--) begin
      if ((acss_pkg::COUNT_BITS'(i) < count) &&
          (acss_pkg::list_entry(channel_list, acss_pkg::IDX_BITS'(i)) == in_channel)) begin
        hit     = 1'b1;
        hit_idx = acss_pkg::IDX_BITS'(i);
      end
    end
  end

  always_comb begin
    entry.op     = acss_pkg::cmd_t'(in_cmd);
    entry.sample = in_sample;
    entry.hit    = 1'b0;
    entry.idx    = '0;
    if (entry.op == acss_pkg::CMD_READ_CH) begin
      entry.hit = hit;
      entry.idx = hit_idx;
    end
  end

endmodule

`default_nettype wire

/* rtl/acss_queue.sv */
// Short FIFO of decoded operations between front end and back end.
// Depends on acss_pkg.
`default_nettype none

module acss_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire acss_pkg::op_entry_t  push_entry,
  input  wire logic                 pop,
  output acss_pkg::op_entry_t       head,
  output acss_pkg::queue_status_t   status
);

  localparam int CNT_BITS = acss_pkg::QPTR_BITS + 1;

  acss_pkg::op_entry_t              slot_r [acss_pkg::QUEUE_DEPTH];
  logic [acss_pkg::QPTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [acss_pkg::QPTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0]              fill_r, fill_nxt;
  logic                             do_push, do_pop;

  assign status  = '{full:  (fill_r == CNT_BITS'(acss_pkg::QUEUE_DEPTH)),
                     empty: (fill_r == '0)};
  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;
  assign head    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == acss_pkg::QPTR_BITS'(acss_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == acss_pkg::QPTR_BITS'(acss_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

/* rtl/acss_back.sv */
// Back end: holds scan state and sample store, executes operations, drives results.
// Depends on acss_pkg.
`default_nettype none

module acss_back (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire acss_pkg::op_entry_t                head,
  input  wire acss_pkg::queue_status_t            qstat,
  output logic                                    pop,
  input  wire logic [acss_pkg::COUNT_BITS-1:0]    count,
  input  wire logic [acss_pkg::LIST_BITS-1:0]     channel_list,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [acss_pkg::STATUS_BITS-1:0]        out_status,
  output logic [acss_pkg::SAMPLE_BITS-1:0]        out_value,
  output logic                                    out_start_conv,
  output logic [acss_pkg::MUX_BITS-1:0]           out_mux_select,
  output logic                                    out_scan_done,
  output logic                                    out_last
);

  typedef enum logic {
    S_EXEC,
    S_DUMP
  } state_t;

  state_t                              state_r, state_nxt;
  logic                                done_r, done_nxt;
  logic [acss_pkg::IDX_BITS-1:0]       pos_r, pos_nxt;
  logic [acss_pkg::IDX_BITS-1:0]       idx_r, idx_nxt;
  logic [acss_pkg::SAMPLE_BITS-1:0]    store_r [acss_pkg::MAX_CHANNELS];

  logic                                valid_r, valid_nxt;
  logic [acss_pkg::STATUS_BITS-1:0]    status_r, status_nxt;
  logic [acss_pkg::SAMPLE_BITS-1:0]    value_r;
  logic                                start_r, start_nxt;
  logic [acss_pkg::MUX_BITS-1:0]       mux_r, mux_nxt;
  logic                                sdone_r, sdone_nxt;
  logic                                last_r, last_nxt;

  logic                                load_ok;
  logic                                load;
  logic                                take_value;
  logic [acss_pkg::IDX_BITS-1:0]       rd_idx;
  logic [acss_pkg::COUNT_BITS-1:0]     pos_inc;
  logic [acss_pkg::COUNT_BITS-1:0]     idx_inc;
  logic                                store_we;

  assign load_ok  = !valid_r || !out_stall;
  assign pop      = (state_r == S_EXEC) && !qstat.empty && load_ok;
  assign rd_idx   = (state_r == S_DUMP) ? idx_r : head.idx;
  assign pos_inc  = acss_pkg::COUNT_BITS'(pos_r) + 1'b1;
  assign idx_inc  = acss_pkg::COUNT_BITS'(idx_r) + 1'b1;
  assign store_we = pop && (head.op == acss_pkg::CMD_CONV) && !done_r;

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[pos_r] <= head.sample;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    done_nxt   = done_r;
    pos_nxt    = pos_r;
    idx_nxt    = idx_r;
    valid_nxt  = valid_r && !load_ok;
    load       = 1'b0;
    take_value = 1'b0;
    status_nxt = acss_pkg::ST_OK;
    start_nxt  = 1'b0;
    mux_nxt    = '0;
    sdone_nxt  = done_r;
    last_nxt   = 1'b1;
    if (pop) begin
      load      = 1'b1;
      valid_nxt = 1'b1;
      unique case (head.op)
        acss_pkg::CMD_START: begin
          if (!done_r) begin
            status_nxt = acss_pkg::ST_BUSY;
          end else begin
            done_nxt  = 1'b0;
            pos_nxt   = '0;
            start_nxt = 1'b1;
            mux_nxt   = acss_pkg::list_entry(channel_list, '0);
            sdone_nxt = 1'b0;
          end
        end
        acss_pkg::CMD_CONV: begin
          if (!done_r) begin
            if (pos_inc < count) begin
              pos_nxt   = pos_inc[acss_pkg::IDX_BITS-1:0];
              start_nxt = 1'b1;
              mux_nxt   = acss_pkg::list_entry(channel_list,
                                               pos_inc[acss_pkg::IDX_BITS-1:0]);
            end else begin
              pos_nxt   = '0;
              done_nxt  = 1'b1;
              sdone_nxt = 1'b1;
            end
          end
        end
        acss_pkg::CMD_READ_CH: begin
          if (head.hit) begin
            take_value = 1'b1;
          end else begin
            status_nxt = acss_pkg::ST_NOT_FOUND;
          end
        end
        acss_pkg::CMD_READ_ALL: begin
          if (!done_r) begin
            status_nxt = acss_pkg::ST_BUSY;
          end else begin
            take_value = 1'b1;
            if (count != acss_pkg::COUNT_BITS'(1)) begin
              last_nxt  = 1'b0;
              idx_nxt   = acss_pkg::IDX_BITS'(1);
              state_nxt = S_DUMP;
            end
          end
        end
        default: begin
        end
      endcase
    end else if ((state_r == S_DUMP) && load_ok) begin
      load       = 1'b1;
      valid_nxt  = 1'b1;
      take_value = 1'b1;
      last_nxt   = (idx_inc == count);
      if (idx_inc == count) begin
        state_nxt = S_EXEC;
        idx_nxt   = '0;
      end else begin
        idx_nxt = idx_inc[acss_pkg::IDX_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_EXEC;
      done_r  <= 1'b1;
      pos_r   <= '0;
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      pos_r   <= pos_nxt;
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
      if (load) begin
        status_r <= status_nxt;
        value_r  <= take_value ? store_r[rd_idx] : '0;
        start_r  <= start_nxt;
        mux_r    <= mux_nxt;
        sdone_r  <= sdone_nxt;
        last_r   <= last_nxt;
      end
    end
  end

  assign out_valid      = valid_r;
  assign out_status     = status_r;
  assign out_value      = value_r;
  assign out_start_conv = start_r;
  assign out_mux_select = mux_r;
  assign out_scan_done  = sdone_r;
  assign out_last       = last_r;

endmodule

`default_nettype wire

/* rtl/adc_channel_scan_sequencer.sv */
// Top level of the ADC channel scan sequencer: config registers, front end, queue, back end.
// Depends on acss_pkg, acss_front, acss_queue, acss_back.
//
//   channel   direction  handshake             payload
//   in_       input      in_valid / in_stall   cmd, sample, channel
//   out_      output     out_valid / out_stall status, value, start_conv, mux_select,
//                                              scan_done, last
//   cfg_      input      cfg_we                cfg_addr, cfg_wdata
//
// A transaction is written into a queue slot at acceptance; the back end pops it and
// registers its result, one per cycle unless out_stall or a read-all dump holds it back.
// Read-all with scan done: one result per unstalled cycle, effective count (1..8) in all.
// in_stall rises when the two-entry queue is full; out_stall holds the output register.
// Synchronous active-low reset; no clearing pass, the sample store is left unreset.
`default_nettype none

module adc_channel_scan_sequencer (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [acss_pkg::CMD_BITS-1:0]         in_cmd,
  input  wire logic [acss_pkg::SAMPLE_BITS-1:0]      in_sample,
  input  wire logic [acss_pkg::MUX_BITS-1:0]         in_channel,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [acss_pkg::STATUS_BITS-1:0]           out_status,
  output logic [acss_pkg::SAMPLE_BITS-1:0]           out_value,
  output logic                                       out_start_conv,
  output logic [acss_pkg::MUX_BITS-1:0]              out_mux_select,
  output logic                                       out_scan_done,
  output logic                                       out_last,
  input  wire logic                                  cfg_we,
  input  wire logic [acss_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
  input  wire logic [acss_pkg::LIST_BITS-1:0]        cfg_wdata
);

  logic [acss_pkg::COUNT_BITS-1:0] active_count_r;
  logic [acss_pkg::LIST_BITS-1:0]  channel_list_r;
  logic [acss_pkg::COUNT_BITS-1:0] count;

  acss_pkg::op_entry_t             front_entry;
  acss_pkg::op_entry_t             head;
  acss_pkg::queue_status_t         qstat;
  logic                            pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_count_r <= acss_pkg::COUNT_RESET;
      channel_list_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        acss_pkg::CFG_ACTIVE_COUNT: active_count_r <= cfg_wdata[acss_pkg::COUNT_BITS-1:0];
        acss_pkg::CFG_CHANNEL_LIST: channel_list_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign count    = acss_pkg::eff_count(active_count_r);
  assign in_stall = qstat.full;

  acss_front u_front (
    .in_cmd       (in_cmd),
    .in_sample    (in_sample),
    .in_channel   (in_channel),
    .count        (count),
    .channel_list (channel_list_r),
    .entry        (front_entry)
  );

  acss_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid),
    .push_entry (front_entry),
    .pop        (pop),
    .head       (head),
    .status     (qstat)
  );

  acss_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .qstat          (qstat),
    .pop            (pop),
    .count          (count),
    .channel_list   (channel_list_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_value      (out_value),
    .out_start_conv (out_start_conv),
    .out_mux_select (out_mux_select),
    .out_scan_done  (out_scan_done),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

/* tb/adc_channel_scan_sequencer_test.sv */
// Self-checking testbench for adc_channel_scan_sequencer: directed and random scans,
// reads and config changes, checked against an in-bench model of the sequencer.
// Depends on acss_pkg and the RTL top level only.
`timescale 1ns / 1ps

module adc_channel_scan_sequencer_test;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 150;
  localparam int RANDOM_GOAL    = 240;

  typedef struct packed {
    logic [acss_pkg::STATUS_BITS-1:0] status;
    logic [acss_pkg::SAMPLE_BITS-1:0] value;
    logic                             start_conv;
    logic [acss_pkg::MUX_BITS-1:0]    mux_select;
    logic                             scan_done;
    logic                             last;
  } reply_t;

  logic                               clk;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [acss_pkg::CMD_BITS-1:0]      in_cmd = '0;
  logic [acss_pkg::SAMPLE_BITS-1:0]   in_sample = '0;
  logic [acss_pkg::MUX_BITS-1:0]      in_channel = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [acss_pkg::STATUS_BITS-1:0]   out_status;
  logic [acss_pkg::SAMPLE_BITS-1:0]   out_value;
  logic                               out_start_conv;
  logic [acss_pkg::MUX_BITS-1:0]      out_mux_select;
  logic                               out_scan_done;
  logic                               out_last;
  logic                               cfg_we = 1'b0;
  logic [acss_pkg::CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [acss_pkg::LIST_BITS-1:0]     cfg_wdata = '0;

  // sequencer model state
  logic [acss_pkg::COUNT_BITS-1:0]  model_count = acss_pkg::COUNT_RESET;
  logic [acss_pkg::LIST_BITS-1:0]   model_list = '0;
  logic [acss_pkg::SAMPLE_BITS-1:0] slot_value [acss_pkg::MAX_CHANNELS];
  bit                               slot_filled [acss_pkg::MAX_CHANNELS] = '{default: 1'b0};
  logic [acss_pkg::IDX_BITS-1:0]    scan_pos = '0;
  bit                               scan_finished = 1'b1;

  reply_t pending_replies[$];
  int     errors = 0;
  int     replies_checked = 0;
  int     items_sent = 0;
  int     config_phases = 0;
  int     gap_pct = 30;
  int     stall_pct = 30;
  int     hold_len = 0;
  int     hold_left = 0;
  int     stall_run = 0;

  adc_channel_scan_sequencer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .in_sample(in_sample), .in_channel(in_channel),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_value(out_value), .out_start_conv(out_start_conv),
    .out_mux_select(out_mux_select), .out_scan_done(out_scan_done), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int active_slots();
    if (model_count == '0) return 1;
    if (model_count > acss_pkg::COUNT_BITS'(acss_pkg::MAX_CHANNELS))
      return acss_pkg::MAX_CHANNELS;
    return int'(model_count);
  endfunction

  function automatic logic [acss_pkg::MUX_BITS-1:0] list_mux(input int i);
    return model_list[i*acss_pkg::MUX_BITS +: acss_pkg::MUX_BITS];
  endfunction

  function automatic int run_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  function automatic void queue_reply(input logic [acss_pkg::STATUS_BITS-1:0] st,
                                      input logic [acss_pkg::SAMPLE_BITS-1:0] val,
                                      input logic conv,
                                      input logic [acss_pkg::MUX_BITS-1:0] mux,
                                      input logic fin);
    reply_t r;
    r.status     = st;
    r.value      = val;
    r.start_conv = conv;
    r.mux_select = mux;
    r.scan_done  = scan_finished;
    r.last       = fin;
    pending_replies.push_back(r);
  endfunction

  // advances the model by one accepted transaction and queues its replies
  function automatic void scan_step(input acss_pkg::cmd_t op,
                                    input logic [acss_pkg::SAMPLE_BITS-1:0] smp,
                                    input logic [acss_pkg::MUX_BITS-1:0] ch);
    int n;
    int i;
    bit hit;
    n = active_slots();
    hit = 1'b0;
    case (op)
      acss_pkg::CMD_START: begin
        if (!scan_finished) begin
          queue_reply(acss_pkg::ST_BUSY, '0, 1'b0, '0, 1'b1);
        end else begin
          scan_finished = 1'b0;
          scan_pos = '0;
          queue_reply(acss_pkg::ST_OK, '0, 1'b1, list_mux(0), 1'b1);
        end
      end
      acss_pkg::CMD_CONV: begin
        if (scan_finished) begin
          queue_reply(acss_pkg::ST_OK, '0, 1'b0, '0, 1'b1);
        end else begin
          slot_value[scan_pos] = smp;
          slot_filled[scan_pos] = 1'b1;
          if (int'(scan_pos) + 1 < n) begin
            scan_pos = scan_pos + 1'b1;
            queue_reply(acss_pkg::ST_OK, '0, 1'b1, list_mux(int'(scan_pos)), 1'b1);
          end else begin
            scan_pos = '0;
            scan_finished = 1'b1;
            queue_reply(acss_pkg::ST_OK, '0, 1'b0, '0, 1'b1);
          end
        end
      end
      acss_pkg::CMD_READ_CH: begin
        for (i = 0; i < n && !hit; i++) begin
          if (list_mux(i) == ch) begin
            queue_reply(acss_pkg::ST_OK, slot_value[i], 1'b0, '0, 1'b1);
            hit = 1'b1;
          end
        end
        if (!hit) queue_reply(acss_pkg::ST_NOT_FOUND, '0, 1'b0, '0, 1'b1);
      end
      default: begin
        if (!scan_finished) begin
          queue_reply(acss_pkg::ST_BUSY, '0, 1'b0, '0, 1'b1);
        end else begin
          for (i = 0; i < n; i++)
            queue_reply(acss_pkg::ST_OK, slot_value[i], 1'b0, '0, i == n - 1);
        end
      end
    endcase
  endfunction

  // true unless the command would read a slot not written since reset
  function automatic bit slot_safe(input acss_pkg::cmd_t op,
                                   input logic [acss_pkg::MUX_BITS-1:0] ch);
    int n;
    int i;
    n = active_slots();
    if (op == acss_pkg::CMD_READ_CH) begin
      for (i = 0; i < n; i++) begin
        if (list_mux(i) == ch) return slot_filled[i];
      end
    end
    if (op == acss_pkg::CMD_READ_ALL && scan_finished) begin
      for (i = 0; i < n; i++) begin
        if (!slot_filled[i]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic send_item(input acss_pkg::cmd_t op,
                           input logic [acss_pkg::SAMPLE_BITS-1:0] smp,
                           input logic [acss_pkg::MUX_BITS-1:0] ch);
    int gap;
    gap = ($urandom_range(0, 99) < gap_pct) ? run_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= op;
    in_sample  <= smp;
    in_channel <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scan_step(op, smp, ch);
    items_sent++;
  endtask

  task automatic send_cmd(input acss_pkg::cmd_t op,
                          input logic [acss_pkg::MUX_BITS-1:0] ch);
    send_item(op, acss_pkg::SAMPLE_BITS'($urandom), ch);
  endtask

  task automatic send_conv(input logic [acss_pkg::SAMPLE_BITS-1:0] smp);
    send_item(acss_pkg::CMD_CONV, smp, acss_pkg::MUX_BITS'($urandom));
  endtask

  // registers change only with no transaction in flight
  task automatic write_reg(input logic [acss_pkg::CFG_ADDR_BITS-1:0] addr,
                           input logic [acss_pkg::LIST_BITS-1:0] data);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == acss_pkg::CFG_ACTIVE_COUNT) model_count = data[acss_pkg::COUNT_BITS-1:0];
    else model_list = data;
    @(posedge clk);
  endtask

  task automatic test_idle_and_full_scan();
    send_conv(10'h3FF);
    send_cmd(acss_pkg::CMD_READ_CH, 5'd5);
    write_reg(acss_pkg::CFG_ACTIVE_COUNT, acss_pkg::LIST_BITS'(8));
    write_reg(acss_pkg::CFG_CHANNEL_LIST,
              {5'd30, 5'd3, 5'd16, 5'd21, 5'd10, 5'd5, 5'd31, 5'd0});
    send_cmd(acss_pkg::CMD_START, 5'd0);
    send_cmd(acss_pkg::CMD_START, 5'd31);
    send_cmd(acss_pkg::CMD_READ_ALL, 5'd0);
    send_cmd(acss_pkg::CMD_READ_CH, 5'd9);
    send_conv(10'd0);
    send_conv(10'h3FF);
    send_conv(10'h2AA);
    send_conv(10'h155);
    send_conv(10'd1);
    send_conv(10'd512);
    send_conv(10'd511);
    send_conv(10'd1022);
    send_cmd(acss_pkg::CMD_READ_ALL, 5'd0);
    send_cmd(acss_pkg::CMD_READ_CH, 5'd0);
    send_cmd(acss_pkg::CMD_READ_CH, 5'd31);
    send_cmd(acss_pkg::CMD_READ_CH, 5'd30);
    send_conv(10'd77);
  endtask

  task automatic test_count_limits();
    send_cmd(acss_pkg::CMD_START, 5'd0);
    send_conv(10'd100);
    send_conv(10'd200);
    // count drops to the current position mid-scan
    write_reg(acss_pkg::CFG_ACTIVE_COUNT, acss_pkg::LIST_BITS'(2));
    send_conv(10'd300);
    send_cmd(acss_pkg::CMD_READ_ALL, 5'd0);
    write_reg(acss_pkg::CFG_ACTIVE_COUNT, acss_pkg::LIST_BITS'(0));
    send_cmd(acss_pkg::CMD_START, 5'd0);
    send_conv(10'd7);
    send_cmd(acss_pkg::CMD_READ_ALL, 5'd0);
    write_reg(acss_pkg::CFG_CHANNEL_LIST, {8{5'd7}});
    write_reg(acss_pkg::CFG_ACTIVE_COUNT, acss_pkg::LIST_BITS'(15));
    send_cmd(acss_pkg::CMD_READ_CH, 5'd7);
    send_cmd(acss_pkg::CMD_START, 5'd0);
    send_cmd(acss_pkg::CMD_READ_CH, 5'd7);
    send_cmd(acss_pkg::CMD_READ_ALL, 5'd0);
  endtask

  // receiver holds off while the sender keeps offering transactions
  task automatic test_output_hold();
    int i;
    write_reg(acss_pkg::CFG_ACTIVE_COUNT, acss_pkg::LIST_BITS'(8));
    write_reg(acss_pkg::CFG_CHANNEL_LIST,
              {5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd29, 5'd31});
    gap_pct = 0;
    stall_pct = 0;
    while (!scan_finished) send_conv(acss_pkg::SAMPLE_BITS'($urandom));
    hold_len = HOLD_CYCLES;
    send_cmd(acss_pkg::CMD_START, 5'd0);
    for (i = 0; i < acss_pkg::MAX_CHANNELS; i++) send_conv(acss_pkg::SAMPLE_BITS'($urandom));
    for (i = 0; i < 3; i++) send_cmd(acss_pkg::CMD_READ_ALL, 5'd0);
  endtask

  task automatic random_config();
    logic [acss_pkg::LIST_BITS-1:0] lst;
    int i;
    case ($urandom_range(0, 5))
      0: write_reg(acss_pkg::CFG_ACTIVE_COUNT, acss_pkg::LIST_BITS'(0));
      1: write_reg(acss_pkg::CFG_ACTIVE_COUNT, acss_pkg::LIST_BITS'(1));
      2: write_reg(acss_pkg::CFG_ACTIVE_COUNT, acss_pkg::LIST_BITS'(8));
      3: write_reg(acss_pkg::CFG_ACTIVE_COUNT, acss_pkg::LIST_BITS'(15));
      default: write_reg(acss_pkg::CFG_ACTIVE_COUNT,
                         acss_pkg::LIST_BITS'($urandom_range(1, 8)));
    endcase
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 3))
        0: lst = '0;
        1: lst = '1;
        2: lst = acss_pkg::LIST_BITS'({$urandom, $urandom});
        default: begin
          for (i = 0; i < acss_pkg::MAX_CHANNELS; i++)
            lst[i*acss_pkg::MUX_BITS +: acss_pkg::MUX_BITS] =
              acss_pkg::MUX_BITS'($urandom_range(0, 3));
        end
      endcase
      write_reg(acss_pkg::CFG_CHANNEL_LIST, lst);
    end
    config_phases++;
  endtask

  task automatic random_item();
    acss_pkg::cmd_t op;
    int r;
    logic [acss_pkg::SAMPLE_BITS-1:0] smp;
    logic [acss_pkg::MUX_BITS-1:0] ch;
    r = $urandom_range(0, 99);
    if (scan_finished) begin
      op = (r < 45) ? acss_pkg::CMD_START :
           (r < 65) ? acss_pkg::CMD_READ_CH :
           (r < 88) ? acss_pkg::CMD_READ_ALL : acss_pkg::CMD_CONV;
    end else begin
      op = (r < 68) ? acss_pkg::CMD_CONV :
           (r < 80) ? acss_pkg::CMD_READ_CH :
           (r < 90) ? acss_pkg::CMD_READ_ALL : acss_pkg::CMD_START;
    end
    case ($urandom_range(0, 9))
      0: smp = '0;
      1: smp = '1;
      default: smp = acss_pkg::SAMPLE_BITS'($urandom);
    endcase
    ch = ($urandom_range(0, 9) < 7) ? list_mux($urandom_range(0, acss_pkg::MAX_CHANNELS - 1))
                                    : acss_pkg::MUX_BITS'($urandom);
    if (!slot_safe(op, ch)) op = acss_pkg::CMD_CONV;
    send_item(op, smp, ch);
  endtask

  task automatic test_random_scans();
    int goal;
    int phase_len;
    int k;
    goal = items_sent + RANDOM_GOAL;
    while (items_sent < goal) begin
      random_config();
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 20;
        default: gap_pct = 50;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 25;
        default: stall_pct = 60;
      endcase
      phase_len = $urandom_range(20, 40);
      for (k = 0; k < phase_len; k++) random_item();
    end
  endtask

  always @(posedge clk) begin
    if (hold_len != 0) begin
      hold_left = hold_len;
      hold_len = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_run > 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_run = run_length() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic report_field(input string name, input int want, input int got);
    $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_status, out_value, out_start_conv, out_mux_select, out_scan_done, out_last};
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected transaction: expected none, actual status %0d value %0d",
                 $time, got.status, got.value);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        replies_checked++;
        if (got.status !== want.status) report_field("status", want.status, got.status);
        if (got.value !== want.value) report_field("value", want.value, got.value);
        if (got.start_conv !== want.start_conv)
          report_field("start_conv", want.start_conv, got.start_conv);
        if (got.mux_select !== want.mux_select)
          report_field("mux_select", want.mux_select, got.mux_select);
        if (got.scan_done !== want.scan_done)
          report_field("scan_done", want.scan_done, got.scan_done);
        if (got.last !== want.last) report_field("last", want.last, got.last);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("adc_channel_scan_sequencer regression: fail");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_and_full_scan();
    test_count_limits();
    test_output_hold();
    test_random_scans();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d transactions, checked %0d results over %0d random config phases",
             items_sent, replies_checked, config_phases);
    $display("covered count 0/1/8/15, duplicate lists, mid-scan count drops, long output hold");
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("adc_channel_scan_sequencer regression: pass");
    end else begin
      $display("adc_channel_scan_sequencer regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/acss_pkg.sv
rtl/acss_front.sv
rtl/acss_queue.sv
rtl/acss_back.sv
rtl/adc_channel_scan_sequencer.sv
tb/adc_channel_scan_sequencer_test.sv
